### rtl/magnetometer_heading_filter_defines.svh
// Assertion macros for the magnetometer heading filter checker.
// Included by rtl/mhf_checker.sv; needs nothing else.
`ifndef MAGNETOMETER_HEADING_FILTER_DEFINES_SVH
`define MAGNETOMETER_HEADING_FILTER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MHF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MHF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mhf_pkg.sv
// Shared widths, constants, register codes and interface structs for the
// magnetometer heading filter. No dependencies.
`timescale 1ns / 1ps

package mhf_pkg;

  localparam int RAW_W       = 16;
  localparam int FIELD_W     = 18;
  localparam int HEAD_W      = 15;
  localparam int OFF_W       = 17;
  localparam int GAIN_W      = 16;
  localparam int SUM_W       = 22;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 17;

  // Shared multiplier operands and product
  localparam int MUL_A_W     = 25;
  localparam int MUL_B_W     = 31;
  localparam int MUL_P_W     = MUL_A_W + MUL_B_W;

  // Rounding and division by the window length
  localparam int NORM_W      = 42;
  localparam int MAG_W       = 24;
  localparam int GAIN_FRAC   = 15;
  localparam int RECIP_SHIFT = 30;

  localparam logic [GAIN_W-1:0] GAIN_ONE = 16'd32768;

  // CORDIC datapath
  localparam int XY_W         = 33;
  localparam int Z_W          = 24;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = 4;
  localparam int XY_SCALE_SH  = 12;
  localparam int HEAD_RND_SH  = 8;

  localparam logic signed [Z_W-1:0] DEG_180    = 24'sd2949120;
  localparam logic signed [Z_W-1:0] DEG_360    = 24'sd5898240;
  localparam logic signed [Z_W-1:0] HEAD_HALF  = 24'sd128;
  localparam logic [HEAD_W-1:0]     HEAD_WRAP  = 15'd23040;

  // atan(2^-i) in 1/16384 degree
  localparam logic [19:0] ATAN_TAB [CORDIC_STEPS] = '{
    20'd737280, 20'd435242, 20'd229970, 20'd116736,
    20'd58595,  20'd29326,  20'd14667,  20'd7334,
    20'd3667,   20'd1833,   20'd917,    20'd458,
    20'd229,    20'd115,    20'd57,     20'd29
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET_X = 3'd0,
    REG_OFFSET_Y = 3'd1,
    REG_OFFSET_Z = 3'd2,
    REG_GAIN_X   = 3'd3,
    REG_GAIN_Y   = 3'd4,
    REG_GAIN_Z   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [RAW_W-1:0] x;
    logic signed [RAW_W-1:0] y;
    logic signed [RAW_W-1:0] z;
  } ring_row_t;

  typedef struct packed {
    logic                      en;
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                      start;
    logic signed [FIELD_W-1:0] fx;
    logic signed [FIELD_W-1:0] fy;
  } cordic_req_t;

  typedef struct packed {
    logic              done;
    logic [HEAD_W-1:0] heading;
  } cordic_rsp_t;

endpackage

### rtl/mhf_ring.sv
// Sample ring: one row of x, y, z per slot, registered read, per-row valid
// bits so that unwritten rows read as zero. Depends on mhf_pkg.
`timescale 1ns / 1ps

module mhf_ring #(
  parameter int DEPTH  = 20,
  parameter int ADDR_W = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output mhf_pkg::ring_row_t  rd_data,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  mhf_pkg::ring_row_t  wr_data
);

  mhf_pkg::ring_row_t mem [DEPTH];
  mhf_pkg::ring_row_t rd_q;
  logic [DEPTH-1:0]   valid;
  logic               rd_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit <= valid[rd_addr];
      end
    end
  end

  // a row never written reads as zero through its cleared valid bit
  assign rd_data = rd_hit ? rd_q : '0;

endmodule

### rtl/mhf_mul.sv
// Shared signed multiplier with a registered product.
// Depends on mhf_pkg.
`timescale 1ns / 1ps

module mhf_mul (
  input  logic                                 clk,
  input  mhf_pkg::mul_req_t                    req,
  output logic signed [mhf_pkg::MUL_P_W-1:0]   prod
);

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod <= req.a * req.b;
    end
  end

endmodule

### rtl/mhf_cordic.sv
// Iterative vectoring CORDIC: heading of (fx, fy) in 1/64 degree, one
// micro-rotation per cycle through one shift-add unit. Depends on mhf_pkg.
`timescale 1ns / 1ps

module mhf_cordic (
  input  logic                 clk,
  input  logic                 rst,
  input  mhf_pkg::cordic_req_t req,
  output mhf_pkg::cordic_rsp_t rsp
);

  localparam int XY_W   = mhf_pkg::XY_W;
  localparam int Z_W    = mhf_pkg::Z_W;
  localparam int STEP_W = mhf_pkg::STEP_W;
  localparam int HEAD_W = mhf_pkg::HEAD_W;

  typedef logic signed [XY_W-1:0] xy_t;
  typedef logic signed [Z_W-1:0]  z_t;

  typedef enum logic [3:0] {
    C_IDLE  = 4'b0001,
    C_ITER  = 4'b0010,
    C_FOLD  = 4'b0100,
    C_ROUND = 4'b1000
  } cstate_t;

  cstate_t           state;
  xy_t               x;
  xy_t               y;
  z_t                z;
  logic [STEP_W-1:0] step;
  logic              zero;

  xy_t               x0;
  xy_t               y0;
  xy_t               xs;
  xy_t               ys;
  z_t                atan_v;
  z_t                hsum;
  logic [HEAD_W-1:0] hraw;

  assign x0     = xy_t'(req.fx) <<< mhf_pkg::XY_SCALE_SH;
  assign y0     = xy_t'(req.fy) <<< mhf_pkg::XY_SCALE_SH;
  assign xs     = x >>> step;
  assign ys     = y >>> step;
  assign atan_v = z_t'(mhf_pkg::ATAN_TAB[step]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      step  <= '0;
    end else begin
      case (state)
        C_IDLE: begin
          if (req.start) begin
            step  <= '0;
            state <= C_ITER;
          end
        end
        C_ITER: begin
          step <= step + 1'b1;
          if (step == STEP_W'(mhf_pkg::CORDIC_STEPS - 1)) begin
            state <= C_FOLD;
          end
        end
        C_FOLD:  state <= C_ROUND;
        C_ROUND: state <= C_IDLE;
        default: state <= C_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      C_IDLE: begin
        if (req.start) begin
          zero <= (req.fx == '0) && (req.fy == '0);
          // left half-plane: turn the vector round and start at 180 degrees
          if (req.fx < 0) begin
            x <= -x0;
            y <= -y0;
            z <= mhf_pkg::DEG_180;
          end else begin
            x <= x0;
            y <= y0;
            z <= '0;
          end
        end
      end
      C_ITER: begin
        if (!y[XY_W-1]) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + atan_v;
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - atan_v;
        end
      end
      C_FOLD: begin
        if (z < 0) begin
          z <= z + mhf_pkg::DEG_360;
        end
      end
      default: ;
    endcase
  end

  assign hsum = z + mhf_pkg::HEAD_HALF;
  assign hraw = hsum[mhf_pkg::HEAD_RND_SH +: HEAD_W];

  always_comb begin
    rsp.done = (state == C_ROUND);
    if (zero) begin
      rsp.heading = '0;
    end else if (hraw >= mhf_pkg::HEAD_WRAP) begin
      rsp.heading = hraw - mhf_pkg::HEAD_WRAP;
    end else begin
      rsp.heading = hraw;
    end
  end

endmodule

### rtl/magnetometer_heading_filter.sv
// Top level of the magnetometer heading filter: sequencer, configuration
// registers and output register. Depends on mhf_pkg, mhf_ring, mhf_mul, mhf_cordic.
`timescale 1ns / 1ps

// Boxcar-averaged compass. Each request carries one raw x/y/z sample; the
// block keeps the last WINDOW samples per axis in a ring (zero after reset,
// tracked with one valid bit per row so there is no clearing pass) and a
// running sum per axis. Per axis it forms (2*sum - offset*WINDOW)*gain,
// divides by WINDOW*32768 with round-half-up and saturates to 18 bits
// (raw units times two), then a 16-step CORDIC gives the heading of
// (field_x, field_y) in 1/64 degree, 0 to 23039, and 0 for a zero vector.
// From acceptance until the result is in the output register a sample
// passes the sum update behind the ring read; per axis the difference, the
// gain product and the reciprocal of WINDOW on the shared multiplier, with
// rounding and saturation; the CORDIC launch, its sixteen micro-rotations
// plus fold and rounding; and the load of the output register. sample_stall
// is high for the whole of that time; the next request is taken the cycle
// after the result is loaded, while it still waits on result_stall, so only
// one sample is in flight at a time. A result held by result_stall
// with the output register still full holds the sequencer, and the input
// with it. Offsets (index 0..2, 17-bit signed, half-LSB units) and
// gains (index 3..5, unsigned Q1.15, reset to one) are written through the
// cfg channel, which is always ready; writes to other indexes are ignored.

module magnetometer_heading_filter #(
  parameter int WINDOW = 20
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    sample_valid,
  output logic                                    sample_stall,
  input  logic signed [mhf_pkg::RAW_W-1:0]        raw_x,
  input  logic signed [mhf_pkg::RAW_W-1:0]        raw_y,
  input  logic signed [mhf_pkg::RAW_W-1:0]        raw_z,
  output logic                                    result_valid,
  input  logic                                    result_stall,
  output logic signed [mhf_pkg::FIELD_W-1:0]      field_x,
  output logic signed [mhf_pkg::FIELD_W-1:0]      field_y,
  output logic signed [mhf_pkg::FIELD_W-1:0]      field_z,
  output logic [mhf_pkg::HEAD_W-1:0]              heading,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [mhf_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [mhf_pkg::CFG_DATA_W-1:0]          cfg_data
);

  localparam int SLOT_W  = $clog2(WINDOW);
  localparam int AW      = mhf_pkg::MUL_A_W;
  localparam int BW      = mhf_pkg::MUL_B_W;
  localparam int PW      = mhf_pkg::MUL_P_W;
  localparam int TW      = mhf_pkg::NORM_W;
  localparam int MAG_W   = mhf_pkg::MAG_W;
  localparam int SUM_W   = mhf_pkg::SUM_W;
  localparam int FIELD_W = mhf_pkg::FIELD_W;
  localparam int OFF_W   = mhf_pkg::OFF_W;
  localparam int GAIN_W  = mhf_pkg::GAIN_W;
  localparam int HEAD_W  = mhf_pkg::HEAD_W;

  // half of WINDOW*32768 for round-half-up, clamp just past saturation,
  // and ceil(2^30 / WINDOW), exact for every quotient below the clamp
  localparam int HALF_BIAS = WINDOW * 16384;
  localparam int N_CLAMP   = WINDOW * 131072 + WINDOW;
  localparam int RECIP     = ((1 << mhf_pkg::RECIP_SHIFT) + WINDOW - 1) / WINDOW;

  localparam logic signed [AW-1:0]      WIN_S     = AW'(WINDOW);
  localparam logic [FIELD_W-1:0]        Q_POS_MAX = FIELD_W'(131071);
  localparam logic [FIELD_W-1:0]        Q_NEG_MAX = FIELD_W'(131072);
  localparam logic signed [FIELD_W-1:0] FIELD_MAX = FIELD_W'(131071);
  localparam logic signed [FIELD_W-1:0] FIELD_MIN = FIELD_W'(-131072);

  typedef logic signed [AW-1:0] wide_t;
  typedef logic signed [TW-1:0] norm_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_READ  = 10'b00_0000_0010,
    ST_DIFF  = 10'b00_0000_0100,
    ST_MUL1  = 10'b00_0000_1000,
    ST_NORM  = 10'b00_0001_0000,
    ST_MUL2  = 10'b00_0010_0000,
    ST_SAT   = 10'b00_0100_0000,
    ST_ANGLE = 10'b00_1000_0000,
    ST_WAIT  = 10'b01_0000_0000,
    ST_DONE  = 10'b10_0000_0000
  } state_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  state_t state;
  state_t state_next;
  axis_t  axis;

  // configuration
  logic signed [OFF_W-1:0] offset_x;
  logic signed [OFF_W-1:0] offset_y;
  logic signed [OFF_W-1:0] offset_z;
  logic [GAIN_W-1:0]       gain_x;
  logic [GAIN_W-1:0]       gain_y;
  logic [GAIN_W-1:0]       gain_z;

  // datapath registers
  mhf_pkg::ring_row_t      raw_q;
  sum_t                    sum_x;
  sum_t                    sum_y;
  sum_t                    sum_z;
  logic [SLOT_W-1:0]       slot;
  wide_t                   diff;
  logic [MAG_W-1:0]        mag;
  logic                    neg;
  logic signed [FIELD_W-1:0] fld_x;
  logic signed [FIELD_W-1:0] fld_y;
  logic signed [FIELD_W-1:0] fld_z;
  logic [HEAD_W-1:0]       head_q;

  // combinational helpers
  logic                    accept;
  logic                    out_load;
  sum_t                    sum_sel;
  logic signed [OFF_W-1:0] off_sel;
  logic [GAIN_W-1:0]       gain_sel;
  wide_t                   diff_next;
  norm_t                   tsum;
  norm_t                   tval;
  norm_t                   mag_full;
  logic [MAG_W-1:0]        mag_next;
  logic [FIELD_W-1:0]      quot;
  logic signed [FIELD_W-1:0] sat_val;

  mhf_pkg::ring_row_t      old_row;
  mhf_pkg::mul_req_t       mul_req;
  logic signed [PW-1:0]    mul_prod;
  mhf_pkg::cordic_req_t    cor_req;
  mhf_pkg::cordic_rsp_t    cor_rsp;

  // Handshakes: one request in flight; config always ready
  assign sample_stall = (state != ST_IDLE);
  assign accept       = sample_valid && !sample_stall;
  assign cfg_ready    = 1'b1;
  assign out_load     = (state == ST_DONE) && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x <= '0;
      offset_y <= '0;
      offset_z <= '0;
      gain_x   <= mhf_pkg::GAIN_ONE;
      gain_y   <= mhf_pkg::GAIN_ONE;
      gain_z   <= mhf_pkg::GAIN_ONE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mhf_pkg::REG_OFFSET_X: offset_x <= $signed(cfg_data[OFF_W-1:0]);
        mhf_pkg::REG_OFFSET_Y: offset_y <= $signed(cfg_data[OFF_W-1:0]);
        mhf_pkg::REG_OFFSET_Z: offset_z <= $signed(cfg_data[OFF_W-1:0]);
        mhf_pkg::REG_GAIN_X:   gain_x   <= cfg_data[GAIN_W-1:0];
        mhf_pkg::REG_GAIN_Y:   gain_y   <= cfg_data[GAIN_W-1:0];
        mhf_pkg::REG_GAIN_Z:   gain_z   <= cfg_data[GAIN_W-1:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // Ring: read the slot being replaced on acceptance, overwrite it in the following cycle
  mhf_ring #(
    .DEPTH  (WINDOW),
    .ADDR_W (SLOT_W)
  ) u_ring (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (slot),
    .rd_data (old_row),
    .wr_en   (state == ST_READ),
    .wr_addr (slot),
    .wr_data (raw_q)
  );

  // Select the axis being corrected
  always_comb begin
    case (axis)
      AXIS_X: begin
        sum_sel  = sum_x;
        off_sel  = offset_x;
        gain_sel = gain_x;
      end
      AXIS_Y: begin
        sum_sel  = sum_y;
        off_sel  = offset_y;
        gain_sel = gain_y;
      end
      AXIS_Z: begin
        sum_sel  = sum_z;
        off_sel  = offset_z;
        gain_sel = gain_z;
      end
      default: begin
        sum_sel  = sum_x;
        off_sel  = offset_x;
        gain_sel = gain_x;
      end
    endcase
  end

  // mean in half-LSB units less the offset, both times WINDOW
  assign diff_next = (wide_t'(sum_sel) <<< 1) - wide_t'(off_sel) * WIN_S;

  // Shared multiplier: gain product, then reciprocal of WINDOW
  always_comb begin
    mul_req.en = 1'b0;
    mul_req.a  = diff;
    mul_req.b  = BW'(gain_sel);
    case (state)
      ST_MUL1: mul_req.en = 1'b1;
      ST_MUL2: begin
        mul_req.en = 1'b1;
        mul_req.a  = AW'(mag);
        mul_req.b  = BW'(RECIP);
      end
      default: ;
    endcase
  end

  mhf_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (mul_prod)
  );

  // Round by 32768, then fold the sign so that the division by WINDOW works
  // on a magnitude: a negative value becomes ceil(-t / WINDOW)
  assign tsum     = $signed(mul_prod[TW-1:0]) + norm_t'(HALF_BIAS);
  assign tval     = tsum >>> mhf_pkg::GAIN_FRAC;
  assign mag_full = tsum[TW-1] ? (norm_t'(WINDOW - 1) - tval) : tval;
  assign mag_next = (mag_full > norm_t'(N_CLAMP)) ? MAG_W'(N_CLAMP) : mag_full[MAG_W-1:0];

  assign quot = mul_prod[mhf_pkg::RECIP_SHIFT +: FIELD_W];

  always_comb begin
    if (!neg) begin
      sat_val = (quot > Q_POS_MAX) ? FIELD_MAX : $signed(quot);
    end else begin
      sat_val = (quot > Q_NEG_MAX) ? FIELD_MIN : -$signed(quot);
    end
  end

  // Heading unit
  assign cor_req.start = (state == ST_ANGLE);
  assign cor_req.fx    = fld_x;
  assign cor_req.fy    = fld_y;

  mhf_cordic u_cordic (
    .clk (clk),
    .rst (rst),
    .req (cor_req),
    .rsp (cor_rsp)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept) state_next = ST_READ;
      ST_READ:  state_next = ST_DIFF;
      ST_DIFF:  state_next = ST_MUL1;
      ST_MUL1:  state_next = ST_NORM;
      ST_NORM:  state_next = ST_MUL2;
      ST_MUL2:  state_next = ST_SAT;
      ST_SAT:   state_next = (axis == AXIS_Z) ? ST_ANGLE : ST_DIFF;
      ST_ANGLE: state_next = ST_WAIT;
      ST_WAIT:  if (cor_rsp.done) state_next = ST_DONE;
      ST_DONE:  if (out_load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      axis  <= AXIS_X;
      slot  <= '0;
      sum_x <= '0;
      sum_y <= '0;
      sum_z <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_READ: begin
          // swap the oldest sample for the new one in each running sum
          sum_x <= sum_x + sum_t'(raw_q.x) - sum_t'(old_row.x);
          sum_y <= sum_y + sum_t'(raw_q.y) - sum_t'(old_row.y);
          sum_z <= sum_z + sum_t'(raw_q.z) - sum_t'(old_row.z);
          slot  <= (slot == SLOT_W'(WINDOW - 1)) ? '0 : slot + 1'b1;
          axis  <= AXIS_X;
        end
        ST_SAT: begin
          case (axis)
            AXIS_X:  axis <= AXIS_Y;
            AXIS_Y:  axis <= AXIS_Z;
            default: axis <= AXIS_X;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Payload registers of the sequencer
  always_ff @(posedge clk) begin
    if (accept) begin
      raw_q <= '{x: raw_x, y: raw_y, z: raw_z};
    end
    case (state)
      ST_DIFF: diff <= diff_next;
      ST_NORM: begin
        mag <= mag_next;
        neg <= tsum[TW-1];
      end
      ST_SAT: begin
        case (axis)
          AXIS_X:  fld_x <= sat_val;
          AXIS_Y:  fld_y <= sat_val;
          default: fld_z <= sat_val;
        endcase
      end
      ST_WAIT: if (cor_rsp.done) head_q <= cor_rsp.heading;
      default: ;
    endcase
  end

  // Output register: hold while stalled, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      field_x <= fld_x;
      field_y <= fld_y;
      field_z <= fld_z;
      heading <= head_q;
    end
  end

endmodule

### rtl/mhf_checker.sv
// Port-level checks on the magnetometer heading filter, bound to the top level.
// Depends on magnetometer_heading_filter_defines.svh.
`timescale 1ns / 1ps
`include "magnetometer_heading_filter_defines.svh"

module mhf_checker (
  input logic        clk,
  input logic        rst,
  input logic        sample_valid,
  input logic        sample_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic [17:0] field_x,
  input logic [17:0] field_y,
  input logic [17:0] field_z,
  input logic [14:0] heading
);

  `MHF_ASSERT_NEXT(a_result_held, clk, rst, result_valid && result_stall, result_valid && $stable(field_x) && $stable(field_y) && $stable(field_z) && $stable(heading), "stalled result changed or vanished")
  `MHF_ASSERT_NEXT(a_one_in_flight, clk, rst, sample_valid && !sample_stall, sample_stall, "second request taken while busy")
  `MHF_ASSERT_NOW(a_heading_range, clk, rst, result_valid, heading < 15'd23040, "heading beyond a full turn")
  `MHF_ASSERT_NOW(a_zero_vector, clk, rst, result_valid && field_x == 18'd0 && field_y == 18'd0, heading == 15'd0, "zero vector gave a heading")

endmodule

bind magnetometer_heading_filter mhf_checker u_mhf_checker (.*);

### tb/sv/tb_magnetometer_heading_filter.sv
// Self-checking testbench for magnetometer_heading_filter: directed and random samples,
// register settings and random idling on both channels, all checked against a predictor.
// Depends on mhf_pkg and the RTL of the block; reads and writes no files.
`timescale 1ns / 1ps

import mhf_pkg::*;

// One corrected reading as the block reports it
typedef struct packed {
  logic signed [FIELD_W-1:0] fx;
  logic signed [FIELD_W-1:0] fy;
  logic signed [FIELD_W-1:0] fz;
  logic [HEAD_W-1:0]         hd;
} compass_reading_t;

class compass_scoreboard #(int WIN = 20);
  localparam longint DEN       = WIN * 32768;
  localparam longint FIELD_TOP = 131071;
  localparam longint FIELD_BOT = -131072;
  localparam longint HALF_TURN = 2949120;
  localparam longint FULL_TURN = 5898240;
  localparam longint HEAD_TOP  = 23040;

  longint offs[3];
  longint gains[3];
  longint ring[3][WIN];
  longint sums[3];
  int     slot;
  longint arc_step[16];

  compass_reading_t expected_readings[$];
  int failures;
  int checked;
  int saturated;
  int zero_vectors;
  int wrapped;

  function new();
    int a;
    int i;
    arc_step = '{737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
                 3667, 1833, 917, 458, 229, 115, 57, 29};
    for (a = 0; a < 3; a++) begin
      offs[a]  = 0;
      gains[a] = 32768;
      sums[a]  = 0;
      for (i = 0; i < WIN; i++) ring[a][i] = 0;
    end
    slot = 0;
  endfunction

  function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_OFFSET_X: offs[0]  = longint'($signed(data));
      REG_OFFSET_Y: offs[1]  = longint'($signed(data));
      REG_OFFSET_Z: offs[2]  = longint'($signed(data));
      REG_GAIN_X:   gains[0] = longint'(data[GAIN_W-1:0]);
      REG_GAIN_Y:   gains[1] = longint'(data[GAIN_W-1:0]);
      REG_GAIN_Z:   gains[2] = longint'(data[GAIN_W-1:0]);
      default: ;
    endcase
  endfunction

  function longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  // Mean in half-LSB units less offset, times gain, round half up, saturate
  function longint average_field(longint sum, longint off, longint gain);
    longint num;
    longint v;
    num = (2 * sum - off * WIN) * gain;
    v = floor_div(2 * num + DEN, 2 * DEN);
    if (v > FIELD_TOP || v < FIELD_BOT) saturated++;
    if (v > FIELD_TOP) v = FIELD_TOP;
    if (v < FIELD_BOT) v = FIELD_BOT;
    return v;
  endfunction

  // Vectoring CORDIC, angle in 1/16384 degree, result in 1/64 degree
  function longint cordic_heading(longint fx, longint fy);
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    longint h;
    int i;
    if (fx == 0 && fy == 0) begin
      zero_vectors++;
      return 0;
    end
    x = fx * 4096;
    y = fy * 4096;
    z = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = HALF_TURN;
    end
    for (i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + arc_step[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - arc_step[i];
      end
    end
    if (z < 0) z = z + FULL_TURN;
    h = (z + 128) >>> 8;
    if (h >= HEAD_TOP) begin
      h = h - HEAD_TOP;
      wrapped++;
    end
    return h;
  endfunction

  function void note_sample(logic signed [RAW_W-1:0] sx, logic signed [RAW_W-1:0] sy,
                            logic signed [RAW_W-1:0] sz);
    longint raw[3];
    longint f[3];
    compass_reading_t r;
    int a;
    raw[0] = sx;
    raw[1] = sy;
    raw[2] = sz;
    for (a = 0; a < 3; a++) begin
      sums[a] += raw[a] - ring[a][slot];
      ring[a][slot] = raw[a];
      f[a] = average_field(sums[a], offs[a], gains[a]);
    end
    slot = (slot + 1 >= WIN) ? 0 : slot + 1;
    r.fx = FIELD_W'(f[0]);
    r.fy = FIELD_W'(f[1]);
    r.fz = FIELD_W'(f[2]);
    r.hd = HEAD_W'(cordic_heading(f[0], f[1]));
    expected_readings.push_back(r);
  endfunction

  function void report_field(string name, longint want, longint got, logic has_x);
    failures++;
    if (has_x)
      $display("%0t ns: %s mismatch, expected %0d, got unknown bits", $time, name, want);
    else
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
  endfunction

  function void check_result(compass_reading_t got);
    compass_reading_t want;
    if (expected_readings.size() == 0) begin
      failures++;
      $display("%0t ns: reading with none outstanding, got x=%0d y=%0d z=%0d heading=%0d",
               $time, $signed(got.fx), $signed(got.fy), $signed(got.fz), got.hd);
      return;
    end
    want = expected_readings.pop_front();
    checked++;
    if (got.fx !== want.fx) report_field("field_x", $signed(want.fx), $signed(got.fx), $isunknown(got.fx));
    if (got.fy !== want.fy) report_field("field_y", $signed(want.fy), $signed(got.fy), $isunknown(got.fy));
    if (got.fz !== want.fz) report_field("field_z", $signed(want.fz), $signed(got.fz), $isunknown(got.fz));
    if (got.hd !== want.hd) report_field("heading", want.hd, got.hd, $isunknown(got.hd));
  endfunction

  function int outstanding();
    return expected_readings.size();
  endfunction
endclass

module tb_magnetometer_heading_filter;

  localparam int WINDOW       = 20;
  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 11;
  // Wait after the last reading is back, longer than a request takes to reach its result
  localparam int DRAIN_CYCLES = 48;
  // Slowest correct run, every request behind the longest gap and stall,
  // stays under two million ns; give it several times that
  localparam int TIMEOUT_NS   = 10_000_000;

  // Indexes past the register list; writes there must leave everything alone
  localparam logic [CFG_IDX_W-1:0] SPARE_IDX_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] SPARE_IDX_B = 3'd7;

  localparam logic signed [RAW_W-1:0] RAW_MAX = 16'sh7FFF;
  localparam logic signed [RAW_W-1:0] RAW_MIN = 16'sh8000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                       sample_valid = 1'b0;
  logic                       sample_stall;
  logic signed [RAW_W-1:0]    raw_x = '0;
  logic signed [RAW_W-1:0]    raw_y = '0;
  logic signed [RAW_W-1:0]    raw_z = '0;
  logic                       result_valid;
  logic                       result_stall = 1'b0;
  logic signed [FIELD_W-1:0]  field_x;
  logic signed [FIELD_W-1:0]  field_y;
  logic signed [FIELD_W-1:0]  field_z;
  logic [HEAD_W-1:0]          heading;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;

  compass_scoreboard #(WINDOW) sb;

  // Chance in a hundred that either side idles; zero during the quiet stretch
  int idle_pct = 35;
  int burst_left = 0;
  int samples_sent = 0;
  int settings_applied = 1;
  int regs_written = 0;

  // Steady field vector for the steady-field requests, redrawn at random now and then
  logic signed [RAW_W-1:0] hold_x = 16'sd1200;
  logic signed [RAW_W-1:0] hold_y = -16'sd700;
  logic signed [RAW_W-1:0] hold_z = 16'sd300;

  magnetometer_heading_filter #(
    .WINDOW(WINDOW)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .raw_x        (raw_x),
    .raw_y        (raw_y),
    .raw_z        (raw_z),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .field_x      (field_x),
    .field_y      (field_y),
    .field_z      (field_z),
    .heading      (heading),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #(CLK_HALF) clk = ~clk;

  // Result side: check each reading taken, then pick the stall for the next cycle.
  // Mostly short random stalls, now and then a long burst that can outlast a whole
  // sample so the next result backs up behind the held one.
  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1 && !result_stall)
      sb.check_result('{fx: field_x, fy: field_y, fz: field_z, hd: heading});
    if (burst_left > 0) begin
      burst_left   <= burst_left - 1;
      result_stall <= 1'b1;
    end else if (idle_pct != 0 && $urandom_range(199) == 0) begin
      burst_left   <= $urandom_range(20, 60);
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  // Present one request and hold it until taken. Valid is left high on return,
  // so the next call either keeps it high or drops it for a gap: never both.
  task automatic present_sample(input logic signed [RAW_W-1:0] sx,
                                input logic signed [RAW_W-1:0] sy,
                                input logic signed [RAW_W-1:0] sz);
    int gap;
    gap = 0;
    if ($urandom_range(99) < idle_pct) gap = $urandom_range(1, 45);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    raw_x        <= sx;
    raw_y        <= sy;
    raw_z        <= sz;
    do @(posedge clk); while (sample_stall !== 1'b0);
    sb.note_sample(sx, sy, sz);
    samples_sent++;
  endtask

  // Drop valid, wait for every outstanding reading, then let the pipe settle
  task automatic drain_results();
    sample_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Start on a fresh edge so cfg_valid is never lowered and raised in one step
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    sb.set_register(idx, data);
    regs_written++;
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_offset(input bit wide);
    if (wide) return CFG_DATA_W'($urandom);
    return CFG_DATA_W'($urandom_range(0, 8192) - 4096);
  endfunction

  // Gains above one are legal; the narrow range straddles one on purpose
  function automatic logic [CFG_DATA_W-1:0] pick_gain(input bit wide);
    if (wide) return CFG_DATA_W'($urandom);
    return CFG_DATA_W'($urandom_range(24000, 40000));
  endfunction

  task automatic random_registers(input bit wide);
    write_reg(REG_OFFSET_X, pick_offset(wide));
    write_reg(REG_OFFSET_Y, pick_offset(wide));
    write_reg(REG_OFFSET_Z, pick_offset(wide));
    write_reg(REG_GAIN_X, pick_gain(wide));
    write_reg(REG_GAIN_Y, pick_gain(wide));
    write_reg(REG_GAIN_Z, pick_gain(wide));
  endtask

  function automatic logic signed [RAW_W-1:0] pick_extreme();
    case ($urandom_range(3))
      0:       return RAW_MAX;
      1:       return RAW_MIN;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // Mix of extremes, near-zero vectors, a steady field with noise (the usual
  // compass case, which settles the boxcar on a heading) and plain noise
  task automatic random_sample();
    logic signed [RAW_W-1:0] vx;
    logic signed [RAW_W-1:0] vy;
    logic signed [RAW_W-1:0] vz;
    if ($urandom_range(39) == 0) begin
      hold_x = RAW_W'($urandom_range(0, 16000) - 8000);
      hold_y = RAW_W'($urandom_range(0, 16000) - 8000);
      hold_z = RAW_W'($urandom_range(0, 16000) - 8000);
    end
    case ($urandom_range(9))
      0, 1: begin
        vx = pick_extreme();
        vy = pick_extreme();
        vz = pick_extreme();
      end
      2, 3: begin
        vx = RAW_W'($urandom_range(0, 16) - 8);
        vy = RAW_W'($urandom_range(0, 16) - 8);
        vz = RAW_W'($urandom_range(0, 16) - 8);
      end
      4, 5, 6: begin
        vx = RAW_W'(int'(hold_x) + $urandom_range(0, 64) - 32);
        vy = RAW_W'(int'(hold_y) + $urandom_range(0, 64) - 32);
        vz = RAW_W'(int'(hold_z) + $urandom_range(0, 64) - 32);
      end
      default: begin
        vx = RAW_W'($urandom);
        vy = RAW_W'($urandom);
        vz = RAW_W'($urandom);
      end
    endcase
    present_sample(vx, vy, vz);
  endtask

  // Random requests; once in a while hold the sender until everything is back
  task automatic run_random(input int count);
    int n;
    for (n = 0; n < count; n++) begin
      random_sample();
      if ($urandom_range(149) == 0) drain_results();
    end
  endtask

  initial begin
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: start-up with the ring still full of zeros. The first
    // request is the zero vector; the third cancels the first two on x to a
    // sum of -1, which rounds back to the zero vector.
    present_sample('0, '0, '0);
    present_sample(RAW_MAX, '0, RAW_MIN);
    present_sample(RAW_MIN, '0, RAW_MAX);
    present_sample(RAW_MIN, RAW_MIN, RAW_MIN);
    present_sample(RAW_MAX, RAW_MAX, RAW_MAX);
    present_sample('0, RAW_MAX, '0);
    present_sample('0, RAW_MIN, '0);
    present_sample(RAW_MIN, RAW_MAX, 16'sd1);
    present_sample(RAW_MAX, RAW_MIN, -16'sd1);
    // Drive x hard negative with y at zero: the half-turn start of the CORDIC,
    // running on past a full window so the ring wraps
    repeat (13) present_sample(RAW_MIN, '0, RAW_MAX);
    run_random(200);

    // Plausible hard- and soft-iron calibration
    drain_results();
    random_registers(1'b0);
    settings_applied++;
    run_random(250);

    // Every bit of every register at random, gains up to almost two
    drain_results();
    random_registers(1'b1);
    settings_applied++;
    run_random(200);

    // Most negative offsets with the largest gain: heavy saturation
    drain_results();
    write_reg(REG_OFFSET_X, CFG_DATA_W'(-65536));
    write_reg(REG_OFFSET_Y, CFG_DATA_W'(-65536));
    write_reg(REG_OFFSET_Z, CFG_DATA_W'(-65536));
    write_reg(REG_GAIN_X, 17'h1FFFF);
    write_reg(REG_GAIN_Y, 17'h1FFFF);
    write_reg(REG_GAIN_Z, 17'h1FFFF);
    settings_applied++;
    run_random(150);

    // Zero gain on x and y: every heading comes from the zero vector
    drain_results();
    write_reg(REG_OFFSET_X, 17'h0FFFF);
    write_reg(REG_OFFSET_Y, 17'h0FFFF);
    write_reg(REG_OFFSET_Z, 17'h0FFFF);
    write_reg(REG_GAIN_X, '0);
    write_reg(REG_GAIN_Y, '0);
    write_reg(REG_GAIN_Z, 17'h08000);
    settings_applied++;
    run_random(60);

    // Back to unity, poke the unused indexes, then run flat out with no idling
    drain_results();
    write_reg(REG_OFFSET_X, '0);
    write_reg(REG_OFFSET_Y, '0);
    write_reg(REG_OFFSET_Z, '0);
    write_reg(REG_GAIN_X, 17'h08000);
    write_reg(REG_GAIN_Y, 17'h08000);
    write_reg(REG_GAIN_Z, 17'h08000);
    write_reg(SPARE_IDX_A, CFG_DATA_W'($urandom));
    write_reg(SPARE_IDX_B, CFG_DATA_W'($urandom));
    settings_applied++;
    idle_pct = 0;
    run_random(250);
    idle_pct = 35;

    drain_results();
    random_registers(1'b0);
    settings_applied++;
    run_random(220);

    drain_results();
    $display("Sent %0d samples across %0d register settings (%0d writes); %0d readings checked.",
             samples_sent, settings_applied, regs_written, sb.checked);
    $display("Saw %0d saturated axes, %0d zero-vector headings and %0d headings wrapped to 0.",
             sb.saturated, sb.zero_vectors, sb.wrapped);
    if (sb.failures == 0 && sb.outstanding() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Hang guard
  initial begin
    #(TIMEOUT_NS);
    $display("Timed out with %0d readings outstanding", sb.outstanding());
    $display("Test completed with failures");
    $finish;
  end

endmodule

### magnetometer_heading_filter.f
+incdir+rtl
rtl/mhf_pkg.sv
rtl/mhf_ring.sv
rtl/mhf_mul.sv
rtl/mhf_cordic.sv
rtl/magnetometer_heading_filter.sv
rtl/mhf_checker.sv
tb/sv/tb_magnetometer_heading_filter.sv
